FILE: sv/aoc_pkg.sv
`timescale 1ns / 1ps

package aoc_pkg;

   // configuration register indexes
   localparam logic [7:0] CSR_ALPHA_IN_LOW_BYTE = 8'd0;
   localparam logic [7:0] CSR_OPACITY           = 8'd1;

   localparam logic [7:0] OPACITY_RESET = 8'hFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CLS_PASS,
      CLS_SOURCE,
      CLS_BLEND
   } aoc_class_type;

   typedef struct packed {
      logic       alpha_in_low_byte;
      logic [7:0] opacity;
   } aoc_cfg_type;

   typedef struct packed {
      logic [31:0]   dst;
      logic [31:0]   src;   // source with its alpha byte already scaled
      logic [7:0]    alpha;
      logic          low;
      aoc_class_type cls;
   } aoc_item_type;

   // rounded division by 255 of x, x at most 255*255
   function automatic logic [7:0] div255_round(input logic [15:0] x);
      logic [15:0] t;
      t = x + 16'd128;
      t = t + (t >> 8);
      return t[15:8];
   endfunction

endpackage

FILE: sv/aoc_intf.sv
`timescale 1ns / 1ps

interface aoc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] dst_pixel;
   logic [31:0] src_pixel;

   modport source (output valid, output dst_pixel, output src_pixel, input ready);
   modport sink   (input valid, input dst_pixel, input src_pixel, output ready);
endinterface

interface aoc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_pixel;

   modport source (output valid, output out_pixel, input ready);
   modport sink   (input valid, input out_pixel, output ready);
endinterface

interface aoc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] addr;
   logic [7:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: sv/aoc_front.sv
`timescale 1ns / 1ps

module aoc_front
   import aoc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  aoc_cfg_type  cfg,
   aoc_req_if.sink      req_bus,
   output aoc_item_type item,
   output logic         item_valid,
   input  logic         item_ready
);

   logic         valid_ff, valid_in;
   aoc_item_type item_ff, item_in;
   logic         load;
   logic [7:0]   src_alpha;
   logic [7:0]   scaled;

   assign req_bus.ready = !valid_ff || item_ready;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      src_alpha = cfg.alpha_in_low_byte ? req_bus.src_pixel[7:0] : req_bus.src_pixel[31:24];
      scaled    = div255_round(16'(src_alpha) * 16'(cfg.opacity));

      item_in.dst   = req_bus.dst_pixel;
      item_in.alpha = scaled;
      item_in.low   = cfg.alpha_in_low_byte;
      if (cfg.alpha_in_low_byte) begin
         item_in.src = {req_bus.src_pixel[31:8], scaled};
      end else begin
         item_in.src = {scaled, req_bus.src_pixel[23:0]};
      end

      // classify: transparent passes destination, opaque takes source, anything between blends
      if (scaled == 8'h00) begin
         item_in.cls = CLS_PASS;
      end else if (scaled == 8'hFF) begin
         item_in.cls = CLS_SOURCE;
      end else begin
         item_in.cls = CLS_BLEND;
      end
   end

   assign valid_in = req_bus.ready ? req_bus.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

FILE: sv/aoc_queue.sv
`timescale 1ns / 1ps

module aoc_queue
   import aoc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  aoc_item_type push_item,
   input  logic         push_valid,
   output logic         push_ready,
   output aoc_item_type pop_item,
   output logic         pop_valid,
   input  logic         pop_ready
);

   aoc_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = count_ff < QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/aoc_back.sv
`timescale 1ns / 1ps

module aoc_back
   import aoc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  aoc_item_type item,
   input  logic         item_valid,
   output logic         item_ready,
   aoc_rsp_if.source    rsp_bus
);

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_pixel_ff;
   logic [31:0] blend_pixel;
   logic [31:0] result;
   logic        pop;

   assign item_ready = !out_valid_ff || rsp_bus.ready;
   assign pop        = item_valid && item_ready;

   // four byte lanes; the alpha lane blends against 255 or 0 by layout
   always_comb begin
      logic [7:0] d_b, s_b, lane, inv;
      logic       is_alpha;
      blend_pixel = '0;
      inv = 8'hFF - item.alpha;
      for (int k = 0; k < 4; k++) begin
         is_alpha = item.low ? (k == 0) : (k == 3);
         d_b = item.dst[8*k +: 8];
         if (is_alpha) begin
            s_b = item.low ? 8'hFF : 8'h00;
         end else begin
            s_b = item.src[8*k +: 8];
         end
         lane = div255_round(16'(d_b) * 16'(inv) + 16'(s_b) * 16'(item.alpha));
         if (is_alpha && !item.low) begin
            lane = lane + item.alpha;
         end
         blend_pixel[8*k +: 8] = lane;
      end
   end

   always_comb begin
      case (item.cls)
         CLS_PASS:   result = item.dst;
         CLS_SOURCE: result = item.src;
         CLS_BLEND:  result = blend_pixel;
         default:    result = item.dst;
      endcase
   end

   assign out_valid_in = item_ready ? item_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_pixel_ff <= result;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.out_pixel = out_pixel_ff;

`ifndef SYNTH
   a_pass_keeps_dst: assert property (@(posedge clock) disable iff (reset)
      (pop && item.cls == CLS_PASS) |=> (out_pixel_ff == $past(item.dst)))
      else $error("pass-through transaction did not keep destination");

   a_source_keeps_src: assert property (@(posedge clock) disable iff (reset)
      (pop && item.cls == CLS_SOURCE) |=> (out_pixel_ff == $past(item.src)))
      else $error("opaque transaction did not take source");

   a_blend_alpha_range: assert property (@(posedge clock) disable iff (reset)
      (pop && item.cls == CLS_BLEND) |-> (item.alpha != 8'h00 && item.alpha != 8'hFF))
      else $error("blend transaction with trivial alpha");
`endif

endmodule

FILE: sv/alpha_over_composite_top.sv
`timescale 1ns / 1ps
// Path from request acceptance to response valid: front classify register,
// queue slot, back output register.
// Throughput: one pixel per cycle while rsp_bus.ready holds; the back lane multipliers set the cycle.
// Reset: synchronous, active high; clears handshake state and the queue,
// sets alpha_in_low_byte to 0 and opacity to 255.

module alpha_over_composite_top
   import aoc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   aoc_req_if.sink   req_bus,
   aoc_rsp_if.source rsp_bus,
   aoc_csr_if.sink   csr_bus
);

   logic         alpha_low_ff, alpha_low_in;
   logic [7:0]   opacity_ff, opacity_in;
   aoc_cfg_type  cfg;
   aoc_item_type front_item, queue_item;
   logic         front_valid, front_ready;
   logic         queue_valid, queue_ready;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      alpha_low_in = alpha_low_ff;
      opacity_in   = opacity_ff;
      if (csr_bus.valid) begin
         case (csr_bus.addr)
            CSR_ALPHA_IN_LOW_BYTE: alpha_low_in = csr_bus.data[0];
            CSR_OPACITY:           opacity_in   = csr_bus.data;
            default:               ;   // drop writes outside the register map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff <= 1'b0;
         opacity_ff   <= OPACITY_RESET;
      end else begin
         alpha_low_ff <= alpha_low_in;
         opacity_ff   <= opacity_in;
      end
   end

   assign cfg.alpha_in_low_byte = alpha_low_ff;
   assign cfg.opacity           = opacity_ff;

   aoc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_bus    (req_bus),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   aoc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (front_item),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_item   (queue_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready)
   );

   aoc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (queue_item),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

import aoc_pkg::*;

class composite_scoreboard;
   logic        low_layout;
   logic [7:0]  opacity;
   logic [31:0] expected_pixels[$];
   int unsigned mismatches;

   function new();
      low_layout = 1'b0;
      opacity    = OPACITY_RESET;
      mismatches = 0;
   endfunction

   // mirror a register write; unknown indexes and bits above a field's width drop out
   function void apply_csr(logic [7:0] index, logic [7:0] value);
      if (index == CSR_ALPHA_IN_LOW_BYTE) begin
         low_layout = value[0];
      end else if (index == CSR_OPACITY) begin
         opacity = value;
      end
   endfunction

   static function logic [7:0] rounded_div255(int unsigned x);
      int unsigned t;
      t = x + 128;
      t = t + (t >> 8);
      return t[15:8];
   endfunction

   function logic [31:0] composite(logic [31:0] dst, logic [31:0] src);
      int unsigned ash;
      int unsigned c0;
      int unsigned sh;
      int unsigned sa;
      int unsigned dc;
      int unsigned sc;
      int unsigned da;
      int unsigned av;
      logic [7:0]  a;
      logic [7:0]  ab;
      logic [31:0] scaled;
      logic [31:0] r;
      ash = low_layout ? 0 : 24;
      sa  = (src >> ash) & 32'hFF;
      a   = rounded_div255(sa * opacity);
      av  = a;
      scaled = low_layout ? {src[31:8], a} : {a, src[23:0]};
      if (a == 8'h00) begin
         return dst;
      end
      if (a == 8'hFF) begin
         return scaled;
      end
      c0 = low_layout ? 8 : 0;
      r  = '0;
      for (int k = 0; k < 3; k++) begin
         sh = c0 + 8 * k;
         dc = (dst >> sh) & 32'hFF;
         sc = (scaled >> sh) & 32'hFF;
         r[sh +: 8] = rounded_div255(dc * (255 - av) + sc * av);
      end
      da = (dst >> ash) & 32'hFF;
      // the two layouts carry different alpha formulas
      if (low_layout) begin
         ab = rounded_div255(da * (255 - av) + 255 * av);
      end else begin
         ab = rounded_div255(da * (255 - av)) + a;
      end
      r[ash +: 8] = ab;
      return r;
   endfunction

   function void note_pixel_pair(logic [31:0] dst, logic [31:0] src);
      expected_pixels.push_back(composite(dst, src));
   endfunction

   function int pending();
      return expected_pixels.size();
   endfunction

   task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch: %s got %08h want %08h", $time, what, got, want);
      mismatches++;
   endtask

   task check_out_pixel(logic [31:0] got);
      logic [31:0] want;
      if (expected_pixels.size() == 0) begin
         report_mismatch("unexpected out_pixel", got, 32'h0);
      end else begin
         want = expected_pixels.pop_front();
         if (got !== want) begin
            report_mismatch("out_pixel", got, want);
         end
      end
   endtask
endclass

module tb_top;
   import aoc_pkg::*;

   localparam int LATENCY        = 3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 75;
   localparam logic [7:0] CSR_OUT_OF_RANGE = CSR_OPACITY + 8'd1;
   localparam logic [7:0] CSR_INDEX_MAX    = 8'hFF;

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   stall_cycles;

   composite_scoreboard sb = new();

   aoc_req_if req_bus ();
   aoc_rsp_if rsp_bus ();
   aoc_csr_if csr_bus ();

   alpha_over_composite_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // monitor: every transaction is sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            sb.apply_csr(csr_bus.addr, csr_bus.data);
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_pixel_pair(req_bus.dst_pixel, req_bus.src_pixel);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_out_pixel(rsp_bus.out_pixel);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [31:0] place_alpha(logic [23:0] color, logic [7:0] alpha, logic low);
      return low ? {color, alpha} : {alpha, color};
   endfunction

   // bias the alpha byte toward the pass-through and opaque cases
   function automatic logic [31:0] random_pixel(logic low);
      logic [31:0] p;
      logic [7:0]  alpha;
      int          pick;
      p    = $urandom;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: alpha = 8'h00;
         2, 3: alpha = 8'hFF;
         4:    alpha = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
         default: alpha = p[15:8] ^ p[31:24];
      endcase
      return place_alpha(p[23:0] ^ p[31:8], alpha, low);
   endfunction

   // start and end on a falling edge; hold valid across back-to-back transactions
   task send_pixel(logic [31:0] dst, logic [31:0] src);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.dst_pixel <= dst;
      req_bus.src_pixel <= src;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task write_csr(logic [7:0] index, logic [7:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task drain();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task directed_layout(logic low);
      send_pixel(32'h0000_0000, 32'h0000_0000);
      send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(place_alpha(24'h123456, 8'h5A, low), place_alpha(24'hFFFFFF, 8'h00, low));
      send_pixel(place_alpha(24'hABCDEF, 8'h33, low), place_alpha(24'h10A0F0, 8'hFF, low));
      send_pixel(place_alpha(24'h000000, 8'h00, low), place_alpha(24'hFFFFFF, 8'h01, low));
      send_pixel(place_alpha(24'hFFFFFF, 8'hFF, low), place_alpha(24'h000000, 8'hFE, low));
      send_pixel(place_alpha(24'h000000, 8'hFF, low), place_alpha(24'hFFFFFF, 8'h80, low));
      send_pixel(place_alpha(24'hFFFFFF, 8'h00, low), place_alpha(24'h000000, 8'h80, low));
      send_pixel(place_alpha(24'h55AA33, 8'h7F, low), place_alpha(24'hC3693C, 8'h40, low));
   endtask

   initial begin
      logic [7:0] opacity_value;
      logic       low;
      reset             = 1'b1;
      stall_cycles      = 0;
      req_idle_pct      = 24;
      rsp_idle_pct      = 82;
      req_bus.valid     = 1'b0;
      req_bus.dst_pixel = '0;
      req_bus.src_pixel = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.addr      = '0;
      csr_bus.data      = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, then low-byte layout, then opacity corners
      directed_layout(1'b0);
      drain();
      write_csr(CSR_ALPHA_IN_LOW_BYTE, 8'h03);
      directed_layout(1'b1);
      drain();
      write_csr(CSR_OPACITY, 8'h00);
      send_pixel(32'h1122_3344, 32'hFFFF_FFFF);
      send_pixel(32'hA5A5_A5A5, 32'h5A5A_5A80);
      drain();
      write_csr(CSR_OPACITY, 8'h01);
      write_csr(CSR_OUT_OF_RANGE, 8'hFF);
      write_csr(CSR_INDEX_MAX, 8'h00);
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FF00, 32'h0000_00FF);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 3) begin
            req_idle_pct = 24;
            rsp_idle_pct = 82;
         end else if (phase < 6) begin
            req_idle_pct = 82;
            rsp_idle_pct = 24;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         low = phase[0];
         case (phase)
            0: opacity_value = 8'hFF;
            1: opacity_value = 8'hFF;
            2: opacity_value = 8'h00;
            3: opacity_value = 8'h80;
            4: opacity_value = 8'h01;
            5: opacity_value = 8'hFE;
            default: opacity_value = $urandom_range(0, 255);
         endcase
         // junk in the upper bits of the layout register must be dropped
         write_csr(CSR_ALPHA_IN_LOW_BYTE, {7'($urandom_range(0, 127)), low});
         write_csr(CSR_OPACITY, opacity_value);
         if (phase == 4) begin
            write_csr(CSR_OUT_OF_RANGE, 8'($urandom_range(0, 255)));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_pixel(random_pixel(low), random_pixel(low));
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
